@@ design/assert_macros.svh @@
// assertion macros shared by the cross-channel normalization rtl
// no dependencies; expects aclk and aresetn in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define CCL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition never true outside reset
`define CCL_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

@@ design/ccl_pkg.sv @@
// types, constants and the exp2 factor table for the cross-channel normalizer
// no dependencies
package ccl_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int SQ_BITS        = 2 * SAMPLE_BITS;
    localparam int MAX_WINDOW_DEF = 15;
    localparam int SUM_BITS       = 36;
    localparam int MANT_BITS      = 31;
    localparam int LOG_STEPS      = 16;
    localparam int TERM_BITS      = 29;
    localparam int S_BITS         = 30;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WINDOW = 2'd0,
        REG_ALPHA  = 2'd1,
        REG_BETA   = 2'd2,
        REG_K      = 2'd3
    } cfg_reg_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t sample;
        logic    last_channel;
    } in_beat_t;

    typedef struct packed {
        sample_t normalized;
        logic    last_out;
    } out_beat_t;

    typedef struct packed {
        logic [3:0]  window_size;
        logic [31:0] alpha_scale;
        logic [15:0] beta_exponent;
        logic [15:0] k_offset;
    } cfg_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    typedef struct packed {
        logic                start;
        logic [SUM_BITS-1:0] sum;
        logic [3:0]          window;
    } pow_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [7:0]    q;
        logic [MANT_BITS-1:0] mant;
    } pow_rsp_t;

    typedef logic [LOG_STEPS-1:0][MANT_BITS-1:0] exp_tbl_t;

    // factors 2^(2^-j), j = 1..16, in Q1.30 by repeated integer square root
    function automatic exp_tbl_t exp_table();
        exp_tbl_t    tbl;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bv;
        tbl = '0;
        t   = 64'd1 << 31;
        for (int j = 0; j < LOG_STEPS; j++) begin
            n   = t << 30;
            res = '0;
            bv  = 64'd1 << 62;
            for (int b = 0; b < 32; b++) begin
                if (n >= res + bv) begin
                    n   = n - (res + bv);
                    res = (res >> 1) + bv;
                end else begin
                    res = res >> 1;
                end
                bv = bv >> 2;
            end
            t      = res;
            tbl[j] = t[MANT_BITS-1:0];
        end
        return tbl;
    endfunction

endpackage

@@ design/ccl_cell.sv @@
// one window cell: holds a sample and its square, passes the sample on
// depends on ccl_pkg
module ccl_cell import ccl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctl_t          ctl,
    input  sample_t            din,
    output sample_t            dout,
    output logic [SQ_BITS-1:0] sq
);

    sample_t                    smp_reg;
    logic [SQ_BITS-1:0]         sq_reg;
    logic [SAMPLE_BITS-1:0]     mag;

    assign mag = din[SAMPLE_BITS-1] ? (~din + 1'b1) : din;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            smp_reg <= '0;
            sq_reg  <= '0;
        end else if (ctl.shift) begin
            smp_reg <= din;
            sq_reg  <= mag * mag;
        end
    end

    assign dout = smp_reg;
    assign sq   = sq_reg;

endmodule

@@ design/ccl_pow.sv @@
// iterative power unit: scaled sum, divide by window, add k, log2, times -beta, exp2
// depends on ccl_pkg
module ccl_pow import ccl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  pow_req_t req,
    output pow_rsp_t rsp
);

    typedef enum logic [3:0] {
        P_IDLE, P_MUL, P_ADD, P_DIV, P_SUMK, P_NORM, P_LOG, P_BETA, P_EXP, P_DONE
    } pstate_t;

    localparam exp_tbl_t EXP_TBL = exp_table();

    pstate_t              state_reg;
    logic [SUM_BITS-1:0]  sum_reg;
    logic [3:0]           w_reg;
    logic [49:0]          phi_reg;
    logic [49:0]          plo_reg;
    logic [TERM_BITS-1:0] quo_reg;
    logic [3:0]           rem_reg;
    logic [4:0]           cnt_reg;
    logic [S_BITS-1:0]    s_reg;
    logic [4:0]           p_reg;
    logic [MANT_BITS-1:0] m_reg;
    logic [15:0]          frac_reg;
    logic signed [39:0]   e_reg;

    logic [50:0]          term_sum;
    logic [4:0]           rem_sh;
    logic                 ge;
    logic [S_BITS-1:0]    s_val;
    logic [61:0]          sq;
    logic [31:0]          t;
    logic signed [5:0]    pm;
    logic signed [21:0]   lg;
    logic signed [38:0]   bprod;
    logic [61:0]          em;
    logic [15:0]          f16;

    assign term_sum = 51'(phi_reg) + 51'(plo_reg[49:18]);
    assign rem_sh   = {rem_reg, quo_reg[TERM_BITS-1]};
    assign ge       = rem_sh >= {1'b0, w_reg};
    assign s_val    = {6'd0, cfg.k_offset, 8'd0} + {1'b0, quo_reg};
    assign sq       = m_reg * m_reg;
    assign t        = sq[61:30];
    assign pm       = $signed({1'b0, p_reg}) - 6'sd16;
    assign lg       = {pm, frac_reg};
    assign bprod    = $signed({1'b0, cfg.beta_exponent}) * lg;
    assign f16      = e_reg[29:14];
    assign em       = m_reg * EXP_TBL[cnt_reg[3:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                P_IDLE: begin
                    if (req.start) begin
                        sum_reg   <= req.sum;
                        w_reg     <= req.window;
                        state_reg <= P_MUL;
                    end
                end
                P_MUL: begin
                    phi_reg   <= cfg.alpha_scale * sum_reg[35:18];
                    plo_reg   <= cfg.alpha_scale * sum_reg[17:0];
                    state_reg <= P_ADD;
                end
                P_ADD: begin
                    quo_reg   <= term_sum[50:22];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= P_DIV;
                end
                P_DIV: begin
                    quo_reg <= {quo_reg[TERM_BITS-2:0], ge};
                    rem_reg <= ge ? 4'(rem_sh - {1'b0, w_reg}) : rem_sh[3:0];
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(TERM_BITS - 1)) begin
                        state_reg <= P_SUMK;
                    end
                end
                P_SUMK: begin
                    s_reg     <= (s_val == '0) ? S_BITS'(1) : s_val;
                    p_reg     <= 5'(S_BITS - 1);
                    state_reg <= P_NORM;
                end
                P_NORM: begin
                    if (s_reg[S_BITS-1]) begin
                        m_reg     <= {s_reg, 1'b0};
                        frac_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= P_LOG;
                    end else begin
                        s_reg <= {s_reg[S_BITS-2:0], 1'b0};
                        p_reg <= p_reg - 5'd1;
                    end
                end
                P_LOG: begin
                    m_reg    <= t[31] ? t[31:1] : t[30:0];
                    frac_reg <= {frac_reg[14:0], t[31]};
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(LOG_STEPS - 1)) begin
                        state_reg <= P_BETA;
                    end
                end
                P_BETA: begin
                    e_reg     <= -40'(bprod);
                    m_reg     <= MANT_BITS'(1) << 30;
                    cnt_reg   <= '0;
                    state_reg <= P_EXP;
                end
                P_EXP: begin
                    if (f16[4'(LOG_STEPS - 1) - cnt_reg[3:0]]) begin
                        m_reg <= em[60:30];
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(LOG_STEPS - 1)) begin
                        state_reg <= P_DONE;
                    end
                end
                P_DONE: begin
                    state_reg <= P_IDLE;
                end
                default: begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = (state_reg == P_DONE);
    assign rsp.q    = e_reg[37:30];
    assign rsp.mant = m_reg;

endmodule

@@ design/cross_channel_lrn_forward.sv @@
// top level of the cross-channel local response normalizer
// depends on ccl_pkg, ccl_cell, ccl_pow and assert_macros.svh
//
// Channel values of one position enter one beat at a time; each result is
// x * (k + alpha/W * sum of squares)^-beta, delayed by half the window, with
// the remaining results flushed after the beat that carries last_channel.
// Items are handled one at a time. A beat that gives a result runs the window
// sum scan, then the iterative power unit (29 divide steps, up to 29
// normalize shifts, 16 log squarings, 16 exp multiplies), then scales and
// loads the output register; a beat without a result runs only the scan.
// A last beat adds one such pass for each of the (W-1)/2 flushed channels.
// The window lives in a shift chain of MAX_WINDOW cells. Configuration must
// be written through the cfg port only while the block is idle; the block
// itself does not enforce this.
`include "assert_macros.svh"
module cross_channel_lrn_forward import ccl_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_beat_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_beat_t                m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    typedef enum logic [2:0] {
        T_IDLE, T_SUM, T_POW, T_WAIT, T_MUL, T_OUT, T_NEXT
    } tstate_t;

    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [3:0] WCAP = 4'((MAX_WINDOW > 15) ? 15 : ((MAX_WINDOW - 1) | 1));
    localparam int AW = ((SQ_BITS > SUM_BITS) ? SQ_BITS : SUM_BITS) + 1;
    localparam int PW = SAMPLE_BITS + MANT_BITS;
    localparam logic [63:0] POSMAX = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    localparam logic [63:0] NEGMAX = 64'd1 << (SAMPLE_BITS - 1);

    tstate_t             state_reg;
    cfg_t                cfg_reg;
    logic [3:0]          cnt_reg;
    logic [3:0]          i_reg;
    logic [2:0]          z_reg;
    logic                last_reg;
    logic [IW-1:0]       idx_reg;
    logic [SUM_BITS-1:0] acc_reg;
    sample_t             x_reg;
    logic [PW-1:0]       prod_reg;
    logic signed [7:0]   q_reg;
    logic                m_valid_reg;
    out_beat_t           out_reg;

    cell_ctl_t           cell_ctl;
    sample_t             shift_din;
    sample_t             smp [MAX_WINDOW];
    logic [SQ_BITS-1:0]  sqr [MAX_WINDOW];

    pow_req_t            req;
    pow_rsp_t            rsp;

    logic [3:0]          w4;
    logic [3:0]          w_eff;
    logic [2:0]          h;
    logic [AW-1:0]       acc_wide;
    logic [SUM_BITS-1:0] acc_sat;
    logic                emit;
    logic                accept;
    logic                out_free;
    logic [SAMPLE_BITS-1:0] ax;
    logic signed [9:0]   sh;
    logic [63:0]         rnd;
    logic [63:0]         r;
    logic [63:0]         rc;
    sample_t             res;

    // window cells
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        if (g == 0) begin : g_head
            ccl_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (cell_ctl),
                .din     (shift_din),
                .dout    (smp[g]),
                .sq      (sqr[g])
            );
        end else begin : g_body
            ccl_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (cell_ctl),
                .din     (smp[g-1]),
                .dout    (smp[g]),
                .sq      (sqr[g])
            );
        end
    end

    ccl_pow u_pow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .req     (req),
        .rsp     (rsp)
    );

    assign w4       = cfg_reg.window_size | 4'd1;
    assign w_eff    = (int'(w4) > MAX_WINDOW) ? WCAP : w4;
    assign h        = w_eff[3:1];
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (5'(i_reg) + 5'(z_reg)) >= 5'(h);

    assign acc_wide = AW'(acc_reg) + AW'(sqr[idx_reg]);
    assign acc_sat  = (acc_wide > AW'(SUM_MAX)) ? SUM_MAX : acc_wide[SUM_BITS-1:0];

    assign shift_din      = (state_reg == T_IDLE) ? s_data.sample : '0;
    assign cell_ctl.shift = accept || (state_reg == T_NEXT && last_reg && z_reg != h);
    assign cell_ctl.clear = (state_reg == T_NEXT) && last_reg && (z_reg == h);

    assign req.start  = (state_reg == T_POW);
    assign req.sum    = acc_reg;
    assign req.window = w_eff;

    // final scaling with round half away from zero and saturation
    assign ax  = x_reg[SAMPLE_BITS-1] ? (~x_reg + 1'b1) : x_reg;
    assign sh  = 10'sd30 - 10'(q_reg);
    assign rnd = (64'(prod_reg) + (64'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
    assign r   = (sh <= 10'sd0) ? '1 : ((sh >= 10'sd63) ? '0 : rnd);
    assign rc  = x_reg[SAMPLE_BITS-1] ? ((r > NEGMAX) ? NEGMAX : r)
                                      : ((r > POSMAX) ? POSMAX : r);
    assign res = (x_reg == '0) ? '0 :
                 (x_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(64'd0 - rc) : SAMPLE_BITS'(rc));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_size   <= 4'd5;
            cfg_reg.alpha_scale   <= 32'd429497;
            cfg_reg.beta_exponent <= 16'd12288;
            cfg_reg.k_offset      <= 16'd256;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WINDOW: cfg_reg.window_size   <= cfg_data[3:0];
                REG_ALPHA:  cfg_reg.alpha_scale   <= cfg_data;
                REG_BETA:   cfg_reg.beta_exponent <= cfg_data[15:0];
                REG_K:      cfg_reg.k_offset      <= cfg_data[15:0];
                default:    cfg_reg.window_size   <= cfg_reg.window_size;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        i_reg     <= cnt_reg;
                        last_reg  <= s_data.last_channel;
                        cnt_reg   <= s_data.last_channel ? 4'd0 :
                                     ((cnt_reg == 4'd15) ? 4'd15 : cnt_reg + 4'd1);
                        z_reg     <= '0;
                        idx_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= T_SUM;
                    end
                end
                T_SUM: begin
                    acc_reg <= acc_sat;
                    if (int'(idx_reg) == int'(h)) begin
                        x_reg <= smp[idx_reg];
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (int'(idx_reg) == int'(w_eff) - 1) begin
                        state_reg <= emit ? T_POW : T_NEXT;
                    end
                end
                T_POW: begin
                    state_reg <= T_WAIT;
                end
                T_WAIT: begin
                    if (rsp.done) begin
                        prod_reg  <= ax * rsp.mant;
                        q_reg     <= rsp.q;
                        state_reg <= T_MUL;
                    end
                end
                T_MUL: begin
                    state_reg <= T_OUT;
                end
                T_OUT: begin
                    if (out_free) begin
                        out_reg.normalized <= res;
                        out_reg.last_out   <= last_reg && (z_reg == h);
                        m_valid_reg        <= 1'b1;
                        state_reg          <= T_NEXT;
                    end
                end
                T_NEXT: begin
                    if (last_reg && z_reg != h) begin
                        z_reg     <= z_reg + 3'd1;
                        idx_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= T_SUM;
                    end else begin
                        state_reg <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == T_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    `CCL_ASSERT(a_accept_sum, (s_valid && s_ready) |=> (state_reg == T_SUM), "beat not summed")
    `CCL_NEVER(a_done_wait, rsp.done && (state_reg != T_WAIT), "power result not awaited")
    `CCL_ASSERT(a_out_load, (state_reg == T_OUT && out_free) |=> m_valid, "result not loaded")

endmodule

@@ test/testbench.sv @@
// self-checking testbench for cross_channel_lrn_forward
// depends on ccl_pkg and the rtl under design; holds its own normalizer model
// in a scoreboard class, drives beats and config writes from tasks and output stalls from an always block
module testbench;
    import ccl_pkg::*;

    class lrn_scoreboard;
        longint           win[15];
        longint unsigned  sq_sum;
        int unsigned      seen;
        logic [3:0]       ws;
        logic [31:0]      alpha;
        logic [15:0]      beta;
        logic [15:0]      k;
        longint unsigned  root_tbl[1:16];
        out_beat_t        expected_q[$];
        int               errors;

        function new();
            longint unsigned t;
            foreach (win[i]) win[i] = 0;
            sq_sum = 0;
            seen   = 0;
            ws     = 4'd5;
            alpha  = 32'd429497;
            beta   = 16'd12288;
            k      = 16'd256;
            errors = 0;
            t      = 64'd1 << 31;
            for (int j = 1; j <= 16; j++) begin
                t           = int_sqrt(t << 30);
                root_tbl[j] = t;
            end
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bv;
            res = 0;
            bv  = 64'd1 << 62;
            while (bv > n) bv = bv >> 2;
            while (bv != 0) begin
                if (n >= res + bv) begin
                    n   = n - (res + bv);
                    res = (res >> 1) + bv;
                end else begin
                    res = res >> 1;
                end
                bv = bv >> 2;
            end
            return res;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [31:0] val);
            case (idx)
                REG_WINDOW: ws    = val[3:0];
                REG_ALPHA:  alpha = val;
                REG_BETA:   beta  = val[15:0];
                REG_K:      k     = val[15:0];
                default: ;
            endcase
        endfunction

        function void shift_in(longint v, int unsigned w);
            longint unsigned acc;
            longint unsigned m;
            acc = 0;
            for (int i = 14; i > 0; i--) win[i] = win[i-1];
            win[0] = v;
            for (int i = 0; i < w; i++) begin
                m   = (win[i] < 0) ? longint'(-win[i]) : win[i];
                acc = acc + m * m;
                if (acc > 64'hF_FFFF_FFFF) acc = 64'hF_FFFF_FFFF;
            end
            sq_sum = acc;
        endfunction

        function sample_t norm_one(longint x, int unsigned w);
            longint unsigned term, s, m, frac, biased, f16, mant, ax, prod, r;
            longint          lg, e, q, sh;
            int              p;
            term = ((longint'(alpha) * (sq_sum >> 18))
                    + ((longint'(alpha) * (sq_sum & 64'h3FFFF)) >> 18)) >> 22;
            term = term / w;
            s    = (longint'(k) << 8) + term;
            if (s == 0) s = 1;
            p = 63;
            while (p > 0 && s[p] == 1'b0) p--;
            m    = (p <= 30) ? (s << (30 - p)) : (s >> (p - 30));
            frac = 0;
            for (int i = 0; i < 16; i++) begin
                m    = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    frac = frac | 1;
                    m    = m >> 1;
                end
            end
            lg     = (longint'(p) - 16) * 65536 + longint'(frac);
            e      = -(longint'(beta) * lg);
            biased = e + (longint'(128) << 30);
            q      = longint'(biased >> 30) - 128;
            f16    = (biased & ((64'd1 << 30) - 1)) >> 14;
            mant   = 64'd1 << 30;
            for (int j = 1; j <= 16; j++)
                if (f16[16-j]) mant = (mant * root_tbl[j]) >> 30;
            if (x == 0) return '0;
            ax   = (x < 0) ? longint'(-x) : x;
            prod = ax * mant;
            sh   = 30 - q;
            if (sh <= 0) r = 64'hFFFF_FFFF_FFFF_FFFF;
            else if (sh >= 63) r = 0;
            else r = (prod + (64'd1 << (sh - 1))) >> sh;
            if (x < 0) begin
                if (r > 32768) r = 32768;
                r = 0 - r;
            end else if (r > 32767) begin
                r = 32767;
            end
            return r[15:0];
        endfunction

        function void note_beat(in_beat_t b);
            out_beat_t   res[8];
            int          n;
            int unsigned w, h, i;
            w = ws | 4'd1;
            h = (w - 1) / 2;
            i = seen;
            n = 0;
            shift_in(longint'(b.sample), w);
            if (i >= h) begin
                res[n] = '{normalized: norm_one(win[h], w), last_out: 1'b0};
                n++;
            end
            if (!b.last_channel) begin
                seen = (i < 15) ? i + 1 : 15;
            end else begin
                for (int z = 1; z <= h; z++) begin
                    shift_in(0, w);
                    if (i + z >= h) begin
                        res[n] = '{normalized: norm_one(win[h], w), last_out: 1'b0};
                        n++;
                    end
                end
                if (n > 0) res[n-1].last_out = 1'b1;
                foreach (win[j]) win[j] = 0;
                sq_sum = 0;
                seen   = 0;
            end
            for (int j = 0; j < n; j++) expected_q = {expected_q, res[j]};
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: normalized=%0d last_out=%0b",
                             got.normalized, got.last_out);
                return;
            end
            want = expected_q.pop_front();
            if (got.normalized !== want.normalized || got.last_out !== want.last_out) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected normalized=%0d last_out=%0b, got %0d %0b",
                             want.normalized, want.last_out, got.normalized, got.last_out);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    lrn_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int hold_total;
    int hold_count = 0;
    int sent;

    cross_channel_lrn_forward DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #60000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: check accepted beats, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (hold_count < hold_total) begin
            hold_count <= hold_count + 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_beat(logic signed [15:0] smp, logic lst);
        s_valid <= 1'b1;
        s_data  <= '{sample: smp, last_channel: lst};
        do @(posedge aclk); while (!s_ready);
        sb.note_beat('{sample: smp, last_channel: lst});
        sent++;
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return $urandom_range(600) - 300;
            3: return $urandom_range(8192) - 4096;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_position(int len);
        for (int c = 0; c < len; c++) send_beat(rand_sample(), c == len - 1);
    endtask

    task automatic random_config();
        wait_idle();
        write_reg(REG_WINDOW, $urandom_range(15));
        case ($urandom_range(3))
            0: write_reg(REG_ALPHA, 32'hFFFF_FFFF);
            1: write_reg(REG_ALPHA, 32'd0);
            default: write_reg(REG_ALPHA, $urandom);
        endcase
        case ($urandom_range(3))
            0: write_reg(REG_BETA, 16'hFFFF);
            1: write_reg(REG_BETA, 16'd0);
            default: write_reg(REG_BETA, $urandom_range(65535));
        endcase
        case ($urandom_range(3))
            0: write_reg(REG_K, 16'hFFFF);
            1: write_reg(REG_K, 16'd1);
            default: write_reg(REG_K, $urandom_range(65535));
        endcase
    endtask

    task automatic random_phase(int target);
        int stop_at;
        stop_at = sent + target;
        while (sent < stop_at) begin
            if ($urandom_range(9) == 0) random_config();
            send_position($urandom_range(9) == 0 ? $urandom_range(16, 20)
                                                 : $urandom_range(1, 9));
        end
    endtask

    initial begin
        sb          = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_WINDOW;
        cfg_data    = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_total  = 0;
        sent        = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes with reset config
        send_beat(16'sh7FFF, 1'b0);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh0000, 1'b0);
        send_beat(16'sh0001, 1'b0);
        send_beat(-16'sh0001, 1'b1);
        // widest window, single-channel position
        wait_idle();
        write_reg(REG_WINDOW, 4'd15);
        write_reg(REG_ALPHA, 32'hFFFF_FFFF);
        write_reg(REG_BETA, 16'hFFFF);
        send_beat(16'sh7FFF, 1'b1);
        // zero denominator
        wait_idle();
        write_reg(REG_K, 16'd0);
        write_reg(REG_ALPHA, 32'd0);
        send_beat(16'sh1234, 1'b0);
        send_beat(16'sh0000, 1'b0);
        send_beat(16'sh8000, 1'b1);
        // even window, no exponent
        wait_idle();
        write_reg(REG_WINDOW, 4'd0);
        write_reg(REG_K, 16'hFFFF);
        write_reg(REG_BETA, 16'd0);
        send_beat(16'sh4000, 1'b0);
        send_beat(16'shC000, 1'b1);
        // window change inside a position
        wait_idle();
        write_reg(REG_WINDOW, 4'd14);
        write_reg(REG_BETA, 16'd12288);
        write_reg(REG_K, 16'd256);
        write_reg(REG_ALPHA, 32'd429497);
        send_beat(16'sh1000, 1'b0);
        send_beat(16'sh2000, 1'b0);
        send_beat(16'shE000, 1'b0);
        wait_idle();
        write_reg(REG_WINDOW, 4'd3);
        send_beat(16'sh0800, 1'b0);
        send_beat(16'sh7000, 1'b1);
        // long position past the channel count limit
        wait_idle();
        write_reg(REG_WINDOW, 4'd7);
        send_position(18);

        idle_pct = 0;  stall_pct = 0;  random_phase(50);
        random_config();
        idle_pct = 87; stall_pct = 0;  random_phase(40);
        random_config();
        idle_pct = 0;  stall_pct = 87; random_phase(50);
        random_config();
        idle_pct = 12; stall_pct = 12; random_phase(50);
        // long receiver hold while beats keep coming
        wait_idle();
        idle_pct = 0; stall_pct = 0;
        hold_total = 3000;
        random_phase(40);

        wait_idle();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ cross_channel_lrn_forward.f @@
+incdir+design
design/ccl_pkg.sv
design/ccl_cell.sv
design/ccl_pow.sv
design/cross_channel_lrn_forward.sv
test/testbench.sv
